FILE: rtl/mscd_pkg.sv
// ----------------------------------------------------------------------------
// mscd_pkg
// Types and codes shared by the countdown timer bank modules.
// ----------------------------------------------------------------------------
package mscd_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    localparam int MASK_W = 6;
    localparam int USED_W = 3;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  owner_id;
        logic [31:0] interval;
        logic        reload_on_expiry;
    } t_in_item;

    typedef struct packed {
        logic [MASK_W-1:0] expired_mask;
        logic              accepted;
        logic [USED_W-1:0] slot_used;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic scan;
        logic apply;
        logic emit;
    } t_dp_cmd;

endpackage

FILE: rtl/mscd_datapath.sv
// ----------------------------------------------------------------------------
// mscd_datapath
// Slot storage, per-slot tick update, owner search and start/stop update.
// ----------------------------------------------------------------------------
module mscd_datapath #(
    parameter int SLOTS = 6,
    parameter int IW    = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mscd_pkg::t_dp_cmd   i_cmd,
    input  logic [IW-1:0]       i_idx,
    input  mscd_pkg::t_in_item  i_item,
    output mscd_pkg::t_out_item o_out_data
);

    logic [7:0]  r_owner    [SLOTS];
    logic [31:0] r_count    [SLOTS];
    logic [31:0] r_period   [SLOTS];
    logic        r_periodic [SLOTS];

    mscd_pkg::t_in_item  r_req;
    mscd_pkg::t_out_item r_out;
    logic [mscd_pkg::MASK_W-1:0] r_mask;
    logic          r_hit;
    logic [IW-1:0] r_hit_idx;
    logic          r_free;
    logic [IW-1:0] r_free_idx;

    logic [IW-1:0] addr;
    logic [7:0]    rd_owner;
    logic [31:0]   rd_count;
    logic [31:0]   rd_period;
    logic          rd_periodic;
    logic [31:0]   cnt_dec;
    logic [31:0]   idx_ext;
    logic [31:0]   diff;
    logic          id_ok;
    logic          acc;
    logic [IW-1:0] used_idx;
    logic [31:0]   used_ext;

    logic          wr_en;
    logic [7:0]    wr_owner;
    logic [31:0]   wr_count;
    logic [31:0]   wr_period;
    logic          wr_periodic;
    logic [mscd_pkg::MASK_W-1:0] n_mask;

    assign id_ok    = (r_req.owner_id != 8'd0);
    assign used_idx = r_hit ? r_hit_idx : r_free_idx;
    assign addr     = i_cmd.apply ? used_idx : i_idx;

    assign rd_owner    = r_owner[addr];
    assign rd_count    = r_count[addr];
    assign rd_period   = r_period[addr];
    assign rd_periodic = r_periodic[addr];

    assign cnt_dec = rd_count - 32'd1;
    assign idx_ext = 32'(i_idx);
    assign diff    = r_req.interval - rd_period;

    always_comb begin
        acc = 1'b0;
        case (r_req.op)
            mscd_pkg::OP_START: acc = id_ok && (r_hit || r_free);
            mscd_pkg::OP_STOP:  acc = id_ok && r_hit;
            default:            acc = 1'b0;
        endcase
    end

    assign used_ext = acc ? 32'(used_idx) : 32'd0;

    always_comb begin
        wr_en       = 1'b0;
        wr_owner    = rd_owner;
        wr_count    = rd_count;
        wr_period   = rd_period;
        wr_periodic = rd_periodic;
        n_mask      = r_mask;
        if (i_cmd.scan && r_req.op == mscd_pkg::OP_TICK && rd_owner != 8'd0) begin
            wr_en    = 1'b1;
            wr_count = cnt_dec;
            if (cnt_dec == 32'd0) begin
                if (idx_ext < 32'(mscd_pkg::MASK_W)) begin
                    n_mask[idx_ext[2:0]] = 1'b1;
                end
                if (rd_periodic) begin
                    wr_count = rd_period;
                end else begin
                    wr_owner = 8'd0;
                end
            end
        end else if (i_cmd.apply && acc) begin
            wr_en = 1'b1;
            if (r_req.op == mscd_pkg::OP_STOP) begin
                wr_owner    = 8'd0;
                wr_count    = 32'd0;
                wr_period   = 32'd0;
                wr_periodic = 1'b0;
            end else if (r_hit) begin
                if (r_req.interval > rd_period) begin
                    wr_count = rd_count + diff;
                end else if (rd_count > r_req.interval) begin
                    wr_count = r_req.interval;
                end
                wr_period   = r_req.interval;
                wr_periodic = r_req.reload_on_expiry;
            end else begin
                wr_owner    = r_req.owner_id;
                wr_count    = r_req.interval;
                wr_period   = r_req.interval;
                wr_periodic = r_req.reload_on_expiry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) begin
                r_owner[k] <= 8'd0;
            end
        end else if (wr_en) begin
            r_owner[addr] <= wr_owner;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_count[addr]    <= wr_count;
            r_period[addr]   <= wr_period;
            r_periodic[addr] <= wr_periodic;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_item;
            r_mask <= '0;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (i_cmd.scan) begin
            r_mask <= n_mask;
            if (!r_hit && rd_owner == r_req.owner_id) begin
                r_hit     <= 1'b1;
                r_hit_idx <= i_idx;
            end
            if (!r_free && rd_owner == 8'd0) begin
                r_free     <= 1'b1;
                r_free_idx <= i_idx;
            end
        end
        if (i_cmd.emit) begin
            r_out.expired_mask <= r_mask;
            r_out.accepted     <= acc;
            r_out.slot_used    <= used_ext[mscd_pkg::USED_W-1:0];
        end
    end

    assign o_out_data = r_out;

endmodule

FILE: rtl/mscd_ctrl.sv
// ----------------------------------------------------------------------------
// mscd_ctrl
// Sequencer: accepts an item, walks the slots, applies the update, emits.
// ----------------------------------------------------------------------------
module mscd_ctrl #(
    parameter int SLOTS = 6,
    parameter int IW    = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output mscd_pkg::t_dp_cmd o_cmd,
    output logic [IW-1:0]     o_idx
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] n_idx;
    logic          r_out_valid;
    logic          n_out_valid;
    logic          out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_idx      = '0;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = ST_APPLY;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            ST_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_idx       = r_idx;

endmodule

FILE: rtl/multi_slot_countdown_timer_bank_top.sv
// An accepted item is loaded, each slot is scanned in turn, the update is applied, then the result is registered.
// A new item is taken only once the previous one is through; the single slot read/write port sets this.
// A result waiting in the output register does not block the next input item.
// Reset (synchronous, active low) frees all slots and clears the handshake state.
// ----------------------------------------------------------------------------
// multi_slot_countdown_timer_bank_top
// Bank of countdown slots with tick, start/retune and stop commands.
// ----------------------------------------------------------------------------
module multi_slot_countdown_timer_bank_top #(
    parameter int SLOTS = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mscd_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mscd_pkg::t_out_item o_out_data
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    mscd_pkg::t_dp_cmd cmd;
    logic [IW-1:0]     idx;

    mscd_ctrl #(
        .SLOTS(SLOTS),
        .IW   (IW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_cmd      (cmd),
        .o_idx      (idx)
    );

    mscd_datapath #(
        .SLOTS(SLOTS),
        .IW   (IW)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_idx     (idx),
        .i_item    (i_in_data),
        .o_out_data(o_out_data)
    );

endmodule

FILE: tb/countdown_bank_watch.sv
// ----------------------------------------------------------------------------
// countdown_bank_watch
// Watches both channels of the countdown timer bank, keeps its own copy of
// the slot table, predicts the result of every accepted item and compares
// each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module countdown_bank_watch #(
    parameter int SLOTS = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  mscd_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  mscd_pkg::t_out_item i_out_data,
    output int                  o_pending,
    output int                  o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]  holder     [SLOTS];
    logic [31:0] remaining  [SLOTS];
    logic [31:0] reload_val [SLOTS];
    logic        repeats    [SLOTS];

    mscd_pkg::t_out_item due_q [$];
    int                  errors = 0;

    function automatic int find_holder(logic [7:0] id);
        for (int s = 0; s < SLOTS; s++) begin
            if (holder[s] == id) return s;
        end
        return -1;
    endfunction

    function automatic mscd_pkg::t_out_item predict_timer_op(mscd_pkg::t_in_item it);
        mscd_pkg::t_out_item res;
        int                  s;
        res = '0;
        case (it.op)
            mscd_pkg::OP_TICK: begin
                for (int k = 0; k < SLOTS; k++) begin
                    if (holder[k] != 8'd0) begin
                        remaining[k] = remaining[k] - 32'd1;
                        if (remaining[k] == 32'd0) begin
                            if (k < mscd_pkg::MASK_W) res.expired_mask[k] = 1'b1;
                            if (repeats[k]) remaining[k] = reload_val[k];
                            else            holder[k]    = 8'd0;
                        end
                    end
                end
            end
            mscd_pkg::OP_START: begin
                if (it.owner_id != 8'd0) begin
                    s = find_holder(it.owner_id);
                    if (s >= 0) begin
                        // retune: grow by the period increase or clip to a shorter one
                        if (it.interval > reload_val[s])
                            remaining[s] = remaining[s] + (it.interval - reload_val[s]);
                        else if (remaining[s] > it.interval)
                            remaining[s] = it.interval;
                    end else begin
                        s = find_holder(8'd0);
                        if (s >= 0) begin
                            remaining[s] = it.interval;
                            holder[s]    = it.owner_id;
                        end
                    end
                    if (s >= 0) begin
                        reload_val[s] = it.interval;
                        repeats[s]    = it.reload_on_expiry;
                        res.accepted  = 1'b1;
                        res.slot_used = s[mscd_pkg::USED_W-1:0];
                    end
                end
            end
            mscd_pkg::OP_STOP: begin
                if (it.owner_id != 8'd0) begin
                    s = find_holder(it.owner_id);
                    if (s >= 0) begin
                        holder[s]     = 8'd0;
                        remaining[s]  = 32'd0;
                        reload_val[s] = 32'd0;
                        repeats[s]    = 1'b0;
                        res.accepted  = 1'b1;
                        res.slot_used = s[mscd_pkg::USED_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        mscd_pkg::t_out_item want;
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) begin
                holder[k]     = 8'd0;
                remaining[k]  = 32'd0;
                reload_val[k] = 32'd0;
                repeats[k]    = 1'b0;
            end
            due_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (due_q.size() == 0) begin
                    $error("result item with no prediction pending: %h", i_out_data);
                    errors++;
                end else begin
                    want = due_q.pop_front();
                    if (i_out_data.expired_mask !== want.expired_mask) begin
                        $error("expired_mask: expected %h, got %h",
                               want.expired_mask, i_out_data.expired_mask);
                        errors++;
                    end
                    if (i_out_data.accepted !== want.accepted) begin
                        $error("accepted: expected %b, got %b",
                               want.accepted, i_out_data.accepted);
                        errors++;
                    end
                    if (i_out_data.slot_used !== want.slot_used) begin
                        $error("slot_used: expected %0d, got %0d",
                               want.slot_used, i_out_data.slot_used);
                        errors++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) due_q.push_back(predict_timer_op(i_in_data));
        end
        o_pending    <= due_q.size();
        o_fail_count <= errors;
    end

endmodule

FILE: tb/multi_slot_countdown_timer_bank_top_test.sv
// ----------------------------------------------------------------------------
// multi_slot_countdown_timer_bank_top_test
// Drives a directed run over the slot table corner cases, then a long random
// mix of ticks, starts, retunes and stops with random idling on both
// channels; the watcher module predicts and compares every result item.
// ----------------------------------------------------------------------------
module multi_slot_countdown_timer_bank_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         SLOTS       = 6;
    localparam logic [1:0] OP_IDLE     = 2'd3;
    localparam int         RAND_ITEMS  = 1750;
    localparam int         TAIL_ITEMS  = 200;
    localparam int         CYCLE_LIMIT = 600000;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    mscd_pkg::t_in_item  i_in_data   = '0;
    logic                i_out_stall = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    mscd_pkg::t_out_item o_out_data;

    int   pending;
    int   fail_count;
    int   cycles     = 0;
    int   stall_left = 0;
    logic quiet_tail = 1'b0;

    always #5 i_clk = ~i_clk;

    multi_slot_countdown_timer_bank_top #(
        .SLOTS(SLOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    countdown_bank_watch #(
        .SLOTS(SLOTS)
    ) watch (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_data  (o_out_data),
        .o_pending   (pending),
        .o_fail_count(fail_count)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side back-pressure in bursts
    always @(posedge i_clk) begin
        if (quiet_tail || !i_rst_n) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic mscd_pkg::t_in_item timer_cmd(logic [1:0] op, logic [7:0] id,
                                                     logic [31:0] ival, logic rel);
        mscd_pkg::t_in_item it;
        it.op               = op;
        it.owner_id         = id;
        it.interval         = ival;
        it.reload_on_expiry = rel;
        return it;
    endfunction

    function automatic mscd_pkg::t_in_item random_cmd();
        mscd_pkg::t_in_item it;
        int                 pick;
        pick = $urandom_range(0, 99);
        it.op = (pick < 50) ? mscd_pkg::OP_TICK  :
                (pick < 78) ? mscd_pkg::OP_START :
                (pick < 94) ? mscd_pkg::OP_STOP  : OP_IDLE;
        pick = $urandom_range(0, 99);
        it.owner_id = (pick < 85) ? 8'($urandom_range(1, 9)) :
                      (pick < 90) ? 8'd0 : 8'($urandom);
        pick = $urandom_range(0, 99);
        it.interval = (pick < 70) ? 32'($urandom_range(0, 12)) :
                      (pick < 85) ? 32'($urandom_range(13, 300)) : 32'($urandom);
        it.reload_on_expiry = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // called at the edge where the previous item was taken, or later
    task automatic send_item(mscd_pkg::t_in_item it);
        int gap;
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(timer_cmd(mscd_pkg::OP_TICK,  8'd0,  32'd0,         1'b0));
        send_item(timer_cmd(mscd_pkg::OP_START, 8'd0,  32'd5,         1'b1));
        send_item(timer_cmd(mscd_pkg::OP_STOP,  8'd0,  32'd0,         1'b0));
        send_item(timer_cmd(mscd_pkg::OP_STOP,  8'h42, 32'd0,         1'b0));
        send_item(timer_cmd(OP_IDLE,            8'hFF, 32'hFFFF_FFFF, 1'b1));
        send_item(timer_cmd(mscd_pkg::OP_START, 8'd1,  32'd1,         1'b0));
        send_item(timer_cmd(mscd_pkg::OP_TICK,  8'd0,  32'd0,         1'b0));
        send_item(timer_cmd(mscd_pkg::OP_START, 8'hFF, 32'hFFFF_FFFF, 1'b1));
        send_item(timer_cmd(mscd_pkg::OP_START, 8'd2,  32'd0,         1'b1));
        // zero count wraps instead of expiring
        send_item(timer_cmd(mscd_pkg::OP_TICK,  8'hA5, 32'h5A5A_5A5A, 1'b1));
        send_item(timer_cmd(mscd_pkg::OP_START, 8'hFF, 32'd3,         1'b0));
        send_item(timer_cmd(mscd_pkg::OP_START, 8'd2,  32'd5,         1'b1));
        send_item(timer_cmd(mscd_pkg::OP_START, 8'd3,  32'd2,         1'b1));
        send_item(timer_cmd(mscd_pkg::OP_START, 8'd4,  32'd7,         1'b0));
        send_item(timer_cmd(mscd_pkg::OP_START, 8'd5,  32'd1,         1'b1));
        send_item(timer_cmd(mscd_pkg::OP_START, 8'd6,  32'd4,         1'b0));
        // bank full
        send_item(timer_cmd(mscd_pkg::OP_START, 8'd7,  32'd4,         1'b1));
        repeat (4) send_item(timer_cmd(mscd_pkg::OP_TICK, 8'd0, 32'd0, 1'b0));
        send_item(timer_cmd(mscd_pkg::OP_STOP,  8'd4,  32'd0,         1'b0));
        send_item(timer_cmd(mscd_pkg::OP_STOP,  8'd5,  32'hFFFF_FFFF, 1'b1));
        drain_results();

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS - TAIL_ITEMS) quiet_tail <= 1'b1;
            if (n % 400 == 399) drain_results();
            send_item(random_cmd());
        end
        i_in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (SLOTS + 10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
